[rtl/core/sdsr_pkg.sv]
package sdsr_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 64;
	localparam int DATA_WIDTH  = 32;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

	// request and result field widths
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int ROLL_W   = 6;
	localparam int COUNT_W  = 7;
	localparam int CMP_W    = (CNT_W > ROLL_W) ? CNT_W : ROLL_W;

	localparam int IN_FIELDS_W  = FUNC_W + VALUE_W + ROLL_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + VALUE_W + 1 + COUNT_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [FUNC_W-1:0] {
		OP_PUSH = 3'd0,
		OP_POP  = 3'd1,
		OP_PEEK = 3'd2,
		OP_DUP  = 3'd3,
		OP_SWAP = 3'd4,
		OP_ROLL = 3'd5
	} op_t;

endpackage

[rtl/core/sdsr_ram.sv]
module sdsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/stack_with_dup_swap_roll_top.sv]
// lifo stack with push, pop, peek, dup, swap and roll over one single-port-pair ram
// the ram has one registered read port: roll reads one entry a cycle and moves it up
// by one place while the next read goes out
// a result register follows the sequencer, so a new request is taken while a result waits
// arst_n clears the fill count, sequencer and result valid; stack words are not cleared
module stack_with_dup_swap_roll_top
	import sdsr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// func [2:0], push_value [34:3], roll_depth [40:35], zero fill above
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// ok [0], read_value [32:1], is_empty [33], entry_count [40:34], zero fill above
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUP_WR,
		ST_ROLL_TOP,
		ST_ROLL_SHIFT,
		ST_ROLL_LAST,
		ST_RESP
	} state_t;

	state_t state_q;

	// request fields
	logic [FUNC_W-1:0]  func;
	logic [VALUE_W-1:0] push_value;
	logic [ROLL_W-1:0]  roll_depth;
	op_t                op_in;

	assign func       = s_axis_tdata[FUNC_W-1:0];
	assign push_value = s_axis_tdata[FUNC_W +: VALUE_W];
	assign roll_depth = s_axis_tdata[FUNC_W + VALUE_W +: ROLL_W];
	assign op_in      = op_t'(func);

	// stack state kept in registers beside the ram
	logic [CNT_W-1:0]      cnt_q;
	logic                  ok_q;       // request was performed
	logic                  rd_sel_q;   // result carries the ram read data
	logic [DATA_WIDTH-1:0] top_q;      // top word held while a roll moves entries up
	logic [ADDR_W-1:0]     last_q;     // address of the latest roll read
	logic [ROLL_W-1:0]     left_q;     // roll reads still to issue

	logic                  m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// ram ports
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [DATA_WIDTH-1:0] rd_data;

	// occupancy checks
	logic              s_accept;
	logic              is_full;
	logic              is_empty_now;
	logic              has_two;
	logic              roll_fits;
	logic [ADDR_W-1:0] top_addr;
	logic [ADDR_W-1:0] push_addr;

	// outcome of the request on offer
	logic              acc_ok;
	logic              acc_rd_sel;
	state_t            acc_state;

	// result register takes the finished request
	logic              resp_load;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;

	assign is_full      = (cnt_q == CNT_W'(STACK_DEPTH));
	assign is_empty_now = (cnt_q == '0);
	assign has_two      = (cnt_q >= CNT_W'(2));
	assign roll_fits    = (CMP_W'(roll_depth) < CMP_W'(cnt_q));
	assign top_addr     = ADDR_W'(cnt_q - CNT_W'(1));
	assign push_addr    = ADDR_W'(cnt_q);

	assign resp_load = (state_q == ST_RESP) && (!m_valid_q || m_axis_tready);

	sdsr_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// bounds check and next step for the request on offer
	always_comb begin
		acc_ok     = 1'b0;
		acc_rd_sel = 1'b0;
		acc_state  = ST_RESP;
		case (op_in)
			OP_PUSH: begin
				acc_ok = !is_full;
			end
			OP_POP, OP_PEEK: begin
				acc_ok     = !is_empty_now;
				acc_rd_sel = !is_empty_now;
			end
			OP_DUP: begin
				if (!is_empty_now && !is_full) begin
					acc_ok    = 1'b1;
					acc_state = ST_DUP_WR;
				end
			end
			OP_SWAP: begin
				// swap is a roll by one place
				if (has_two) begin
					acc_ok    = 1'b1;
					acc_state = ST_ROLL_TOP;
				end
			end
			OP_ROLL: begin
				if (roll_fits) begin
					acc_ok = 1'b1;
					if (roll_depth != '0) begin
						acc_state = ST_ROLL_TOP;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// ram access per sequencer step
	// a roll reads downward and writes each word one place up; the write is always above
	// the read, so the two ports never touch the same entry in one cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					case (op_in)
						OP_PUSH: begin
							if (!is_full) begin
								wr_en   = 1'b1;
								wr_addr = push_addr;
								wr_data = DATA_WIDTH'(push_value);
							end
						end
						OP_POP, OP_PEEK: begin
							if (!is_empty_now) begin
								rd_en   = 1'b1;
								rd_addr = top_addr;
							end
						end
						OP_DUP: begin
							if (!is_empty_now && !is_full) begin
								rd_en   = 1'b1;
								rd_addr = top_addr;
							end
						end
						OP_SWAP: begin
							if (has_two) begin
								rd_en   = 1'b1;
								rd_addr = top_addr;
							end
						end
						OP_ROLL: begin
							if (roll_fits && (roll_depth != '0)) begin
								rd_en   = 1'b1;
								rd_addr = top_addr;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_DUP_WR: begin
				wr_en   = 1'b1;
				wr_addr = push_addr;
				wr_data = rd_data;
			end
			ST_ROLL_TOP: begin
				rd_en   = 1'b1;
				rd_addr = last_q - ADDR_W'(1);
			end
			ST_ROLL_SHIFT: begin
				wr_en   = 1'b1;
				wr_addr = last_q + ADDR_W'(1);
				wr_data = rd_data;
				if (left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = last_q - ADDR_W'(1);
				end
			end
			ST_ROLL_LAST: begin
				wr_en   = 1'b1;
				wr_addr = last_q;
				wr_data = top_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer, stack count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ok_q      <= 1'b0;
			rd_sel_q  <= 1'b0;
			top_q     <= '0;
			last_q    <= '0;
			left_q    <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (resp_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						ok_q     <= acc_ok;
						rd_sel_q <= acc_rd_sel;
						state_q  <= acc_state;
						case (op_in)
							OP_PUSH: begin
								if (!is_full) begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_POP: begin
								if (!is_empty_now) begin
									cnt_q <= cnt_q - CNT_W'(1);
								end
							end
							OP_SWAP: begin
								if (has_two) begin
									last_q <= top_addr;
									left_q <= ROLL_W'(1);
								end
							end
							OP_ROLL: begin
								if (roll_fits && (roll_depth != '0)) begin
									last_q <= top_addr;
									left_q <= roll_depth;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DUP_WR: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= ST_RESP;
				end
				ST_ROLL_TOP: begin
					top_q   <= rd_data;
					last_q  <= last_q - ADDR_W'(1);
					left_q  <= left_q - ROLL_W'(1);
					state_q <= ST_ROLL_SHIFT;
				end
				ST_ROLL_SHIFT: begin
					if (left_q != '0) begin
						last_q <= last_q - ADDR_W'(1);
						left_q <= left_q - ROLL_W'(1);
					end else begin
						state_q <= ST_ROLL_LAST;
					end
				end
				ST_ROLL_LAST: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					// ram read data holds here since no read is issued in this step
					if (resp_load) begin
						m_data_q  <= {
							{OUT_PAD_W{1'b0}},
							COUNT_W'(cnt_q),
							is_empty_now,
							(rd_sel_q ? VALUE_W'(rd_data) : {VALUE_W{1'b0}}),
							ok_q
						};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

[bench/stack_with_dup_swap_roll_top_tb.sv]
`timescale 1ns / 100ps

module stack_with_dup_swap_roll_top_tb;
	import sdsr_pkg::*;

	// func codes that the block refuses
	localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

	// cycles with no request or result accepted before the run is called hung
	localparam int WATCHDOG_LIMIT = 4000;
	// longest request is roll by 63, plus the result register
	localparam int DRAIN_CYCLES   = 100;
	localparam int RANDOM_ITEMS   = 2000;

	typedef struct packed {
		logic                ok;
		logic [VALUE_W-1:0]  read_value;
		logic                is_empty;
		logic [COUNT_W-1:0]  entry_count;
	} stack_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// func [2:0], push_value [34:3], roll_depth [40:35], zero fill above
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// ok [0], read_value [32:1], is_empty [33], entry_count [40:34], zero fill above
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// shadow stack, updated as each request is accepted
	logic [DATA_WIDTH-1:0]  model_words [STACK_DEPTH];
	int unsigned            model_fill = 0;

	// results still owed by the block, oldest first
	stack_result_t          pending_results [$];
	stack_result_t          expected_result;
	stack_result_t          actual_result;

	int                     error_count = 0;
	int                     idle_cycles = 0;

	// sender burst control
	int                     burst_left = 1;
	bit                     sender_gaps_on = 1'b1;

	// receiver stall pattern
	int                     rx_mode = 0;
	int                     rx_mode_left = 0;
	int                     rx_stall_left = 0;
	logic                   rx_ready_next;

	stack_with_dup_swap_roll_top DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// applies one request to the shadow stack and returns the result it should give
	function automatic stack_result_t stack_model_apply(logic [FUNC_W-1:0] func,
			logic [VALUE_W-1:0] value, logic [ROLL_W-1:0] depth);
		stack_result_t         res;
		logic [DATA_WIDTH-1:0] top_word;
		int unsigned           n;
		res = '0;
		n = model_fill;
		case (func)
		OP_PUSH: begin
			if (n < STACK_DEPTH) begin
				model_words[n] = value[DATA_WIDTH-1:0];
				n++;
				res.ok = 1'b1;
			end
		end
		OP_POP: begin
			if (n > 0) begin
				n--;
				res.read_value = model_words[n];
				res.ok = 1'b1;
			end
		end
		OP_PEEK: begin
			if (n > 0) begin
				res.read_value = model_words[n - 1];
				res.ok = 1'b1;
			end
		end
		OP_DUP: begin
			// needs a top to copy and a free slot above it
			if (n > 0 && n < STACK_DEPTH) begin
				model_words[n] = model_words[n - 1];
				n++;
				res.ok = 1'b1;
			end
		end
		OP_SWAP: begin
			if (n >= 2) begin
				top_word = model_words[n - 1];
				model_words[n - 1] = model_words[n - 2];
				model_words[n - 2] = top_word;
				res.ok = 1'b1;
			end
		end
		OP_ROLL: begin
			// top sinks to depth, the entries above that depth rise by one
			if (depth < n) begin
				top_word = model_words[n - 1];
				for (int k = 0; k < depth; k++)
					model_words[n - 1 - k] = model_words[n - 2 - k];
				model_words[n - 1 - depth] = top_word;
				res.ok = 1'b1;
			end
		end
		default: ;
		endcase
		model_fill = n;
		res.is_empty = (n == 0);
		res.entry_count = n[COUNT_W-1:0];
		return res;
	endfunction

	// data words with the extremes and single set bits mixed in
	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
		3: return ~(VALUE_W'(1) << $urandom_range(0, VALUE_W - 1));
		default: return $urandom;
		endcase
	endfunction

	// offers one request, waits for it to be taken, records its result,
	// then maybe opens a gap before the next burst
	task automatic send_request(input logic [FUNC_W-1:0] func,
			input logic [VALUE_W-1:0] value, input logic [ROLL_W-1:0] depth);
		logic [IN_TDATA_W-1:0] packed_req;
		int                    gap;
		packed_req = '0;
		packed_req[0 +: FUNC_W] = func;
		packed_req[FUNC_W +: VALUE_W] = value;
		packed_req[FUNC_W + VALUE_W +: ROLL_W] = depth;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= packed_req;
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(stack_model_apply(func, value, depth));
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_gaps_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// holds off the sender until every result owed has come back
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// every operation but push against an empty stack, plus the spare func codes
	task automatic test_empty_stack();
		send_request(OP_POP, '1, '1);
		send_request(OP_PEEK, '0, '0);
		send_request(OP_DUP, '1, '0);
		send_request(OP_SWAP, '0, '1);
		send_request(OP_ROLL, '1, '0);
		send_request(OP_ROLL, '0, '1);
		send_request(FUNC_SPARE_6, '1, '1);
		send_request(FUNC_SPARE_7, '0, '0);
	endtask

	// each operation on a shallow stack, with refusals at the edges
	task automatic test_basic_ops();
		send_request(OP_PUSH, '0, '1);
		send_request(OP_SWAP, '1, '0);          // one entry only: refused
		send_request(OP_ROLL, '0, 6'd1);        // depth equals count: refused
		send_request(OP_PUSH, '1, '0);
		send_request(OP_PEEK, '0, '0);
		send_request(OP_DUP, '0, '0);
		send_request(OP_SWAP, '0, '0);
		send_request(OP_PUSH, 32'h1234_5678, '0);
		send_request(OP_ROLL, '0, '0);          // depth zero: ok, no change
		send_request(OP_ROLL, '0, 6'd3);        // top goes to the bottom
		send_request(OP_ROLL, '0, 6'd4);        // depth equals count: refused
		send_request(FUNC_SPARE_6, '0, '0);
		send_request(OP_POP, '0, '0);
		send_request(OP_POP, '0, '0);
		send_request(OP_POP, '0, '0);
		send_request(OP_POP, '0, '0);
		send_request(OP_POP, '0, '0);           // empty again: refused
	endtask

	// fill to the top, exercise the full cases and the deepest roll, then empty
	task automatic test_full_stack();
		for (int i = 0; i < STACK_DEPTH; i++)
			send_request(OP_PUSH, pick_word(), ROLL_W'($urandom));
		send_request(OP_PUSH, pick_word(), '0);  // full: refused
		send_request(OP_DUP, '0, '0);            // full: refused
		send_request(OP_ROLL, '0, 6'd63);
		send_request(OP_ROLL, '0, 6'd62);
		send_request(OP_SWAP, '0, '0);
		send_request(OP_PEEK, '0, '0);
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_request(OP_POP, '0, ROLL_W'($urandom));
	endtask

	// random traffic with a drifting bias so the fill level sweeps its whole range
	task automatic test_random_traffic(input int n_items);
		int                 sent;
		int                 bias;
		int                 push_w;
		int                 pop_w;
		int                 r;
		logic [FUNC_W-1:0]  func;
		logic [ROLL_W-1:0]  depth;
		sent = 0;
		bias = 0;
		push_w = 40;
		pop_w = 15;
		while (sent < n_items) begin
			if (sent % 150 == 0) begin
				bias = $urandom_range(0, 3);
				case (bias)
				0: begin push_w = 40; pop_w = 15; end  // grow
				1: begin push_w = 15; pop_w = 45; end  // shrink
				2: begin push_w = 25; pop_w = 25; end  // hover
				default: begin push_w = 50; pop_w = 8; end  // pin at full
				endcase
			end
			if (sent % 300 == 0)
				sender_gaps_on = $urandom_range(0, 2) != 0;
			if (sent > 0 && sent % 500 == 0)
				wait_results_drained();

			// roll depth: mostly a legal one, sometimes anything
			if (model_fill > 0 && $urandom_range(0, 4) != 0)
				depth = ($urandom_range(0, 3) == 0) ? ROLL_W'(model_fill - 1) :
					ROLL_W'($urandom_range(0, model_fill - 1));
			else
				depth = ROLL_W'($urandom);

			if ($urandom_range(0, 63) == 0) begin
				// spare code, refused by the block
				func = $urandom_range(0, 1) ? FUNC_SPARE_6 : FUNC_SPARE_7;
				send_request(func, pick_word(), ROLL_W'($urandom));
			end else begin
				r = $urandom_range(0, 99);
				if (r < push_w)
					func = OP_PUSH;
				else if (r < push_w + pop_w)
					func = OP_POP;
				else begin
					case ($urandom_range(0, 3))
					0: func = OP_PEEK;
					1: func = OP_DUP;
					2: func = OP_SWAP;
					default: func = OP_ROLL;
					endcase
				end
				send_request(func, pick_word(), depth);
				sent++;
			end
		end
	endtask

	// result checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			actual_result.ok = m_axis_tdata[0];
			actual_result.read_value = m_axis_tdata[1 +: VALUE_W];
			actual_result.is_empty = m_axis_tdata[1 + VALUE_W];
			actual_result.entry_count = m_axis_tdata[2 + VALUE_W +: COUNT_W];
			if (pending_results.size() == 0) begin
				$error("result with no request pending: tdata %h", m_axis_tdata);
				error_count++;
			end else begin
				expected_result = pending_results.pop_front();
				if (actual_result.ok !== expected_result.ok) begin
					$error("ok: expected %0d, got %0d",
						expected_result.ok, actual_result.ok);
					error_count++;
				end
				if (actual_result.read_value !== expected_result.read_value) begin
					$error("read_value: expected %h, got %h",
						expected_result.read_value, actual_result.read_value);
					error_count++;
				end
				if (actual_result.is_empty !== expected_result.is_empty) begin
					$error("is_empty: expected %0d, got %0d",
						expected_result.is_empty, actual_result.is_empty);
					error_count++;
				end
				if (actual_result.entry_count !== expected_result.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						expected_result.entry_count, actual_result.entry_count);
					error_count++;
				end
				// fill bits above the fields must stay zero
				if ((m_axis_tdata >> OUT_FIELDS_W) !== '0) begin
					$error("zero fill: expected %h, got %h",
						OUT_TDATA_W'(0), m_axis_tdata >> OUT_FIELDS_W);
					error_count++;
				end
			end
		end
	end

	// receiver: switches among four stall styles at random
	always @(posedge clk) begin
		if (rx_mode_left <= 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(50, 300);
		end
		rx_mode_left--;
		case (rx_mode)
		0: rx_ready_next = 1'b1;                       // never stalls
		1: rx_ready_next = 1'($urandom_range(0, 1));   // coin flip
		2: begin                                       // rare long stalls
			if (rx_stall_left > 0) begin
				rx_stall_left--;
				rx_ready_next = 1'b0;
			end else if ($urandom_range(0, 15) == 0) begin
				rx_stall_left = $urandom_range(1, 20);
				rx_ready_next = 1'b0;
			end else
				rx_ready_next = 1'b1;
		end
		default: rx_ready_next = ~m_axis_tready;       // alternates ready and stall
		endcase
		m_axis_tready <= rx_ready_next;
	end

	// watchdog: a run of cycles where neither side moves means a hang
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("stack_with_dup_swap_roll_top: mismatch");
			$finish;
		end
	end

	initial begin
		// reset held low from the start, released on a rising edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		wait_results_drained();
		test_basic_ops();
		wait_results_drained();
		test_full_stack();
		wait_results_drained();
		test_random_traffic(RANDOM_ITEMS);

		// let everything owed arrive, then watch for strays
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_results.size() == 0)
			$display("stack_with_dup_swap_roll_top: match");
		else
			$display("stack_with_dup_swap_roll_top: mismatch");
		$finish;
	end

endmodule

[sim.f]
rtl/core/sdsr_pkg.sv
rtl/core/sdsr_ram.sv
rtl/core/stack_with_dup_swap_roll_top.sv
bench/stack_with_dup_swap_roll_top_tb.sv
